// ===== sv/dcor3_pkg.sv =====
// ----------------------------------------------------------------------------
// dcor3_pkg: shared constants for the 3D distance correlation block
// Widths of the wide datapath, the bit-serial units and the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dcor3_pkg;

  // Width of one coordinate field on the input ports.
  localparam int FieldW = 24;
  // Wide accumulator / covariance width (all sums fit well below this).
  localparam int TW     = 96;
  // Half width: roots of TW-bit values, multiplier operand, row and grand sums.
  localparam int HW     = 48;
  // Per-axis magnitude after scaling, and a distance.
  localparam int MagW   = 24;
  localparam int DistW  = 25;
  // Sum of three squared magnitudes.
  localparam int SqW    = 52;
  // Result fields.
  localparam int CorrW  = 17;
  localparam int SampW  = 11;
  // Quotient width and root iteration counts.
  localparam int QW     = 32;
  localparam int DistIt = 26;
  localparam int TIt    = 48;
  localparam int QIt    = 16;

  // Which of the three cross terms is being worked on.
  localparam logic [1:0] SUB_AA = 2'd0;
  localparam logic [1:0] SUB_BB = 2'd1;
  localparam logic [1:0] SUB_AB = 2'd2;

  localparam logic [CorrW-1:0] CORR_ONE = CorrW'(65536);

endpackage
`default_nettype wire

// ===== sv/dcor3_ram.sv =====
// ----------------------------------------------------------------------------
// dcor3_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dcor3_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/distance_correlation_3d.sv =====
// ----------------------------------------------------------------------------
// distance_correlation_3d: distance correlation of two 3D point tracks
// Loads time samples of points A and B, then computes the V-statistic
// distance correlation with one shared shift-add multiplier, one bit-serial
// square root and one bit-serial divider under a state sequencer.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake              | Payload
//   --------+------------------------+------------------------------------------
//   input   | in_valid_i / in_stall_o | a_x_i a_y_i a_z_i b_x_i b_y_i b_z_i
//           |                        | last_sample_i
//   output  | out_valid_o/out_stall_i| correlation_o degenerate_o sample_total_o
//
// Samples are taken one per cycle while the block is idle. After the item
// marked last, the block works through all N*N ordered sample pairs; each
// pair takes six squares and three products in the shift-add multiplier and
// two bit-serial distance roots, and a final step then combines the sums.
// The input is stalled from the last item until the result item is taken.
// Reset clears the sample count and the sequencer; the sample memory is
// not cleared, since only entries written in the current run are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module distance_correlation_3d
  import dcor3_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int COORD_BITS  = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [FieldW-1:0] a_x_i,
  input  wire logic [FieldW-1:0] a_y_i,
  input  wire logic [FieldW-1:0] a_z_i,
  input  wire logic [FieldW-1:0] b_x_i,
  input  wire logic [FieldW-1:0] b_y_i,
  input  wire logic [FieldW-1:0] b_z_i,
  input  wire logic              last_sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CorrW-1:0]       correlation_o,
  output logic                   degenerate_o,
  output logic [SampW-1:0]       sample_total_o
);

  localparam int CB  = COORD_BITS;
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int EW  = 6 * CB;
  // Differences wider than 24 bits are scaled down to keep squares in range.
  localparam int DSH = (CB > 24) ? (CB - 24) : 0;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_ROWRD  = 5'd1;
  localparam logic [4:0] ST_ROWLAT = 5'd2;
  localparam logic [4:0] ST_COLRD  = 5'd3;
  localparam logic [4:0] ST_COLLAT = 5'd4;
  localparam logic [4:0] ST_SQSET  = 5'd5;
  localparam logic [4:0] ST_SQADD  = 5'd6;
  localparam logic [4:0] ST_DSET   = 5'd7;
  localparam logic [4:0] ST_DSTO   = 5'd8;
  localparam logic [4:0] ST_PSET   = 5'd9;
  localparam logic [4:0] ST_PADD   = 5'd10;
  localparam logic [4:0] ST_RSET   = 5'd11;
  localparam logic [4:0] ST_RADD   = 5'd12;
  localparam logic [4:0] ST_CSET   = 5'd13;
  localparam logic [4:0] ST_CADD1  = 5'd14;
  localparam logic [4:0] ST_CADD2  = 5'd15;
  localparam logic [4:0] ST_CFIN   = 5'd16;
  localparam logic [4:0] ST_SA     = 5'd17;
  localparam logic [4:0] ST_SB     = 5'd18;
  localparam logic [4:0] ST_PMUL   = 5'd19;
  localparam logic [4:0] ST_CMP    = 5'd20;
  localparam logic [4:0] ST_DIV    = 5'd21;
  localparam logic [4:0] ST_QSQ    = 5'd22;
  localparam logic [4:0] ST_CORR   = 5'd23;
  localparam logic [4:0] ST_OUT    = 5'd24;
  localparam logic [4:0] ST_MUL    = 5'd25;
  localparam logic [4:0] ST_SQRT   = 5'd26;

  // Control state.
  logic [4:0]       state_q, state_d, ret_q, ret_d;
  logic [SampW-1:0] cnt_q, cnt_d, n_q, n_d, k_q, k_d, l_q, l_d;

  // Datapath state.
  logic [EW-1:0]    row_q, row_d, col_q, col_d;
  logic             side_q, side_d;
  logic [1:0]       axis_q, axis_d, sub_q, sub_d;
  logic [SqW-1:0]   sumsq_q, sumsq_d;
  logic [DistW-1:0] dist_q [2];
  logic [DistW-1:0] dist_d [2];
  logic [HW-1:0]    rs_q [2];
  logic [HW-1:0]    rs_d [2];
  logic [HW-1:0]    g_q [2];
  logic [HW-1:0]    g_d [2];
  logic [TW-1:0]    s1_q [3];
  logic [TW-1:0]    s1_d [3];
  logic [TW-1:0]    s3_q [3];
  logic [TW-1:0]    s3_d [3];
  logic [TW-1:0]    t_q [3];
  logic [TW-1:0]    t_d [3];
  logic [TW-1:0]    pos_q, pos_d;
  logic [HW-1:0]    sa_q, sa_d;

  // Shared multiplier, root and divider registers.
  logic [TW-1:0]    acc_q, acc_d, mcand_q, mcand_d;
  logic [HW-1:0]    mplier_q, mplier_d;
  logic [TW-1:0]    rad_q, rad_d;
  logic [HW-1:0]    root_q, root_d;
  logic [HW+1:0]    srem_q, srem_d;
  logic [5:0]       scnt_q, scnt_d, dcnt_q, dcnt_d;
  logic [TW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;

  // Result registers.
  logic [CorrW-1:0] corr_q, corr_d;
  logic             degen_q, degen_d;

  // Sample memory.
  logic             ram_we;
  logic [EW-1:0]    ram_wdata, ram_rdata;
  logic [AW-1:0]    ram_raddr;

  logic             in_acc;

  function automatic logic [CB-1:0] take_coord(input logic [FieldW-1:0] f);
    logic [FieldW+CB-1:0] ext;
    ext = {{CB{1'b0}}, f};
    return ext[CB-1:0];
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ram_we     = in_acc && (cnt_q < SampW'(MAX_SAMPLES));
  assign ram_wdata  = {take_coord(b_z_i), take_coord(b_y_i), take_coord(b_x_i),
                       take_coord(a_z_i), take_coord(a_y_i), take_coord(a_x_i)};
  assign ram_raddr  = (state_q == ST_ROWRD) ? k_q[AW-1:0] : l_q[AW-1:0];

  dcor3_ram #(
    .Width (EW),
    .Depth (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = (state_q == ST_OUT);
  assign correlation_o  = corr_q;
  assign degenerate_o   = degen_q;
  assign sample_total_o = n_q;

  always_comb begin
    logic [CB-1:0]      rc, cc;
    logic [CB:0]        diff, mabs;
    logic [CB+MagW:0]   mext;
    logic [MagW-1:0]    mag;
    logic               fi, si;
    logic [HW+3:0]      rnext, trial;
    logic [TW:0]        r2;
    logic [2*SampW-1:0] nsq;

    state_d  = state_q;
    ret_d    = ret_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    k_d      = k_q;
    l_d      = l_q;
    row_d    = row_q;
    col_d    = col_q;
    side_d   = side_q;
    axis_d   = axis_q;
    sub_d    = sub_q;
    sumsq_d  = sumsq_q;
    dist_d   = dist_q;
    rs_d     = rs_q;
    g_d      = g_q;
    s1_d     = s1_q;
    s3_d     = s3_q;
    t_d      = t_q;
    pos_d    = pos_q;
    sa_d     = sa_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rad_d    = rad_q;
    root_d   = root_q;
    srem_d   = srem_q;
    scnt_d   = scnt_q;
    dcnt_d   = dcnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    corr_d   = corr_q;
    degen_d  = degen_q;

    // Coordinate of the current side and axis in the row and column samples.
    rc   = row_q[(32'(side_q) * 3 + 32'(axis_q)) * CB +: CB];
    cc   = col_q[(32'(side_q) * 3 + 32'(axis_q)) * CB +: CB];
    diff = {rc[CB-1], rc} - {cc[CB-1], cc};
    mabs = diff[CB] ? (~diff + 1'b1) : diff;
    mext = {{MagW{1'b0}}, mabs >> DSH};
    mag  = mext[MagW-1:0];

    // Operand selection for the three cross terms: AA, BB and AB.
    fi = (sub_q == SUB_BB);
    si = (sub_q != SUB_AA);

    rnext = {srem_q, rad_q[TW-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    r2    = {rem_q, 1'b0};
    nsq   = n_q * n_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (ram_we) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (last_sample_i) begin
            n_d     = ram_we ? (cnt_q + 1'b1) : cnt_q;
            k_d     = '0;
            s1_d[0] = '0;
            s1_d[1] = '0;
            s1_d[2] = '0;
            s3_d[0] = '0;
            s3_d[1] = '0;
            s3_d[2] = '0;
            g_d[0]  = '0;
            g_d[1]  = '0;
            state_d = ST_ROWRD;
          end
        end
      end
      ST_ROWRD: state_d = ST_ROWLAT;
      ST_ROWLAT: begin
        row_d   = ram_rdata;
        rs_d[0] = '0;
        rs_d[1] = '0;
        l_d     = '0;
        state_d = ST_COLRD;
      end
      ST_COLRD: state_d = ST_COLLAT;
      ST_COLLAT: begin
        col_d   = ram_rdata;
        side_d  = 1'b0;
        axis_d  = '0;
        sumsq_d = '0;
        state_d = ST_SQSET;
      end
      ST_SQSET: begin
        mcand_d  = TW'(mag);
        mplier_d = HW'(mag);
        acc_d    = '0;
        ret_d    = ST_SQADD;
        state_d  = ST_MUL;
      end
      ST_SQADD: begin
        sumsq_d = sumsq_q + acc_q[SqW-1:0];
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = ST_DSET;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_SQSET;
        end
      end
      ST_DSET: begin
        rad_d   = TW'(sumsq_q) << (2 * (HW - DistIt));
        root_d  = '0;
        srem_d  = '0;
        scnt_d  = 6'(DistIt);
        ret_d   = ST_DSTO;
        state_d = ST_SQRT;
      end
      ST_DSTO: begin
        dist_d[side_q] = root_q[DistW-1:0];
        rs_d[side_q]   = rs_q[side_q] + HW'(root_q[DistW-1:0]);
        if (!side_q) begin
          side_d  = 1'b1;
          sumsq_d = '0;
          state_d = ST_SQSET;
        end else begin
          sub_d   = SUB_AA;
          state_d = ST_PSET;
        end
      end
      ST_PSET: begin
        mcand_d  = TW'(dist_q[fi]);
        mplier_d = HW'(dist_q[si]);
        acc_d    = '0;
        ret_d    = ST_PADD;
        state_d  = ST_MUL;
      end
      ST_PADD: begin
        s1_d[sub_q] = s1_q[sub_q] + acc_q;
        if (sub_q == SUB_AB) begin
          l_d = l_q + 1'b1;
          if (l_q + 1'b1 == n_q) begin
            sub_d   = SUB_AA;
            state_d = ST_RSET;
          end else begin
            state_d = ST_COLRD;
          end
        end else begin
          sub_d   = sub_q + 1'b1;
          state_d = ST_PSET;
        end
      end
      ST_RSET: begin
        mcand_d  = TW'(rs_q[fi]);
        mplier_d = rs_q[si];
        acc_d    = '0;
        ret_d    = ST_RADD;
        state_d  = ST_MUL;
      end
      ST_RADD: begin
        s3_d[sub_q] = s3_q[sub_q] + acc_q;
        if (sub_q == SUB_AB) begin
          g_d[0] = g_q[0] + rs_q[0];
          g_d[1] = g_q[1] + rs_q[1];
          k_d    = k_q + 1'b1;
          if (k_q + 1'b1 == n_q) begin
            sub_d   = SUB_AA;
            state_d = ST_CSET;
          end else begin
            state_d = ST_ROWRD;
          end
        end else begin
          sub_d   = sub_q + 1'b1;
          state_d = ST_RSET;
        end
      end
      ST_CSET: begin
        // N^2 times the pair sum.
        mcand_d  = s1_q[sub_q];
        mplier_d = HW'(nsq);
        acc_d    = '0;
        ret_d    = ST_CADD1;
        state_d  = ST_MUL;
      end
      ST_CADD1: begin
        // Plus the product of the grand sums.
        pos_d    = acc_q;
        mcand_d  = TW'(g_q[fi]);
        mplier_d = g_q[si];
        acc_d    = '0;
        ret_d    = ST_CADD2;
        state_d  = ST_MUL;
      end
      ST_CADD2: begin
        // Minus 2N times the row-sum products.
        pos_d    = pos_q + acc_q;
        mcand_d  = s3_q[sub_q];
        mplier_d = HW'({n_q, 1'b0});
        acc_d    = '0;
        ret_d    = ST_CFIN;
        state_d  = ST_MUL;
      end
      ST_CFIN: begin
        t_d[sub_q] = (pos_q > acc_q) ? (pos_q - acc_q) : '0;
        if (sub_q == SUB_AB) begin
          state_d = ST_SA;
        end else begin
          sub_d   = sub_q + 1'b1;
          state_d = ST_CSET;
        end
      end
      ST_SA: begin
        if (t_q[SUB_AA] == '0 || t_q[SUB_BB] == '0) begin
          degen_d = 1'b1;
          corr_d  = '0;
          state_d = ST_OUT;
        end else begin
          degen_d = 1'b0;
          rad_d   = t_q[SUB_AA];
          root_d  = '0;
          srem_d  = '0;
          scnt_d  = 6'(TIt);
          ret_d   = ST_SB;
          state_d = ST_SQRT;
        end
      end
      ST_SB: begin
        sa_d    = root_q;
        rad_d   = t_q[SUB_BB];
        root_d  = '0;
        srem_d  = '0;
        scnt_d  = 6'(TIt);
        ret_d   = ST_PMUL;
        state_d = ST_SQRT;
      end
      ST_PMUL: begin
        mcand_d  = TW'(sa_q);
        mplier_d = root_q;
        acc_d    = '0;
        ret_d    = ST_CMP;
        state_d  = ST_MUL;
      end
      ST_CMP: begin
        // acc now holds the product of the two roots and serves as divisor.
        if (t_q[SUB_AB] >= acc_q) begin
          corr_d  = CORR_ONE;
          state_d = ST_OUT;
        end else begin
          rem_d   = t_q[SUB_AB];
          quo_d   = '0;
          dcnt_d  = 6'(QW);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (r2 >= {1'b0, acc_q}) begin
          rem_d = TW'(r2 - {1'b0, acc_q});
          quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_d = r2[TW-1:0];
          quo_d = {quo_q[QW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 6'd1) begin
          state_d = ST_QSQ;
        end
      end
      ST_QSQ: begin
        rad_d   = TW'(quo_q) << (2 * (HW - QIt));
        root_d  = '0;
        srem_d  = '0;
        scnt_d  = 6'(QIt);
        ret_d   = ST_CORR;
        state_d = ST_SQRT;
      end
      ST_CORR: begin
        corr_d  = CorrW'(root_q[QIt-1:0]);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (mplier_q == '0) begin
          state_d = ret_q;
        end else begin
          if (mplier_q[0]) begin
            acc_d = acc_q + mcand_q;
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      ST_SQRT: begin
        if (rnext >= trial) begin
          srem_d = (HW+2)'(rnext - trial);
          root_d = {root_q[HW-2:0], 1'b1};
        end else begin
          srem_d = rnext[HW+1:0];
          root_d = {root_q[HW-2:0], 1'b0};
        end
        rad_d  = rad_q << 2;
        scnt_d = scnt_q - 1'b1;
        if (scnt_q == 6'd1) begin
          state_d = ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      l_q     <= '0;
      side_q  <= 1'b0;
      axis_q  <= '0;
      sub_q   <= SUB_AA;
      scnt_q  <= '0;
      dcnt_q  <= '0;
      corr_q  <= '0;
      degen_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      k_q     <= k_d;
      l_q     <= l_d;
      side_q  <= side_d;
      axis_q  <= axis_d;
      sub_q   <= sub_d;
      scnt_q  <= scnt_d;
      dcnt_q  <= dcnt_d;
      corr_q  <= corr_d;
      degen_q <= degen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    col_q    <= col_d;
    sumsq_q  <= sumsq_d;
    dist_q   <= dist_d;
    rs_q     <= rs_d;
    g_q      <= g_d;
    s1_q     <= s1_d;
    s3_q     <= s3_d;
    t_q      <= t_d;
    pos_q    <= pos_d;
    sa_q     <= sa_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rad_q    <= rad_d;
    root_q   <= root_d;
    srem_q   <= srem_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
  end

endmodule
`default_nettype wire
